// ===== src/emp_pkg.sv =====
// Shared types and codes for the extent map engine.
package emp_pkg;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_SHRINK = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APP_RD,
        ST_APP_EV,
        ST_LKP_RD,
        ST_LKP_EV,
        ST_SHR_RD,
        ST_SHR_EV,
        ST_SHR_FIN,
        ST_FREE_RD,
        ST_FREE_OUT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_last;
        logic rd_idx;
        logic append;
        logic step_lookup;
        logic step_shrink;
        logic finish;
        logic rd_free;
        logic load_single;
        logic load_free;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic hit;
        logic nf_zero;
        logic free_last;
        logic out_free;
    } sts_t;

endpackage

// ===== src/emp_ctrl.sv =====
// Controller state machine for the extent map engine.
module emp_ctrl
    import emp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] s_tuser,
    output logic       s_tready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    unique case (s_tuser)
                        REQ_APPEND: state_next = ST_APP_RD;
                        REQ_LOOKUP: state_next = ST_LKP_RD;
                        REQ_SHRINK: state_next = ST_SHR_RD;
                        default:    state_next = ST_RESULT;
                    endcase
                end
            end
            ST_APP_RD: begin
                cmd.rd_last = 1'b1;
                state_next  = ST_APP_EV;
            end
            ST_APP_EV: begin
                cmd.append = 1'b1;
                state_next = ST_RESULT;
            end
            ST_LKP_RD: begin
                if (sts.walk_done) begin
                    state_next = ST_RESULT;
                end else begin
                    cmd.rd_idx = 1'b1;
                    state_next = ST_LKP_EV;
                end
            end
            ST_LKP_EV: begin
                cmd.step_lookup = 1'b1;
                state_next      = sts.hit ? ST_RESULT : ST_LKP_RD;
            end
            ST_SHR_RD: begin
                if (sts.walk_done) begin
                    state_next = ST_SHR_FIN;
                end else begin
                    cmd.rd_idx = 1'b1;
                    state_next = ST_SHR_EV;
                end
            end
            ST_SHR_EV: begin
                cmd.step_shrink = 1'b1;
                state_next      = ST_SHR_RD;
            end
            ST_SHR_FIN: begin
                cmd.finish = 1'b1;
                state_next = sts.nf_zero ? ST_RESULT : ST_FREE_RD;
            end
            ST_FREE_RD: begin
                cmd.rd_free = 1'b1;
                state_next  = ST_FREE_OUT;
            end
            ST_FREE_OUT: begin
                if (sts.out_free) begin
                    cmd.load_free = 1'b1;
                    state_next    = sts.free_last ? ST_IDLE : ST_FREE_RD;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.load_single = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== src/emp_dp.sv =====
// Datapath for the extent map engine: extent table, walk unit, freed-range buffer.
module emp_dp
    import emp_pkg::*;
#(
    parameter int MAX_EXTENTS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [127:0] s_tdata,
    input  cmd_t         cmd,
    output sts_t         sts,
    input  logic         m_tready,
    output logic         m_tvalid,
    output logic [135:0] m_tdata,
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

    logic [31:0] ext_first [MAX_EXTENTS];
    logic [31:0] ext_count [MAX_EXTENTS];
    logic [31:0] free_st   [MAX_EXTENTS];
    logic [31:0] free_ln   [MAX_EXTENTS];

    logic [31:0] start_reg, len_reg, lblk_reg, keep_reg;
    logic [31:0] rd_first_reg, rd_count_reg, rd_fs_reg, rd_fl_reg;
    logic [CW-1:0] used_reg, idx_reg, newn_reg, nf_reg, fidx_reg;
    logic [31:0] blocks_reg, off_reg, acc_reg, nb_reg;
    logic [32:0] phys_reg;
    logic        status_reg;

    logic        m_valid_reg, m_status_reg, m_fv_reg, m_last_reg;
    logic [32:0] m_phys_reg;
    logic [31:0] m_fs_reg, m_fl_reg, m_blocks_reg;
    logic [5:0]  m_total_reg;

    logic [AW-1:0] last_addr, ra, wa;
    logic          we;
    logic [31:0]   wf, wc;
    logic          merged, full;
    logic [31:0]   sum_oc, head, cnt_final, acc_n;
    logic          keep_whole, retain;

    assign last_addr = AW'(used_reg - 1'b1);
    assign ra        = cmd.rd_last ? last_addr : idx_reg[AW-1:0];

    assign merged = (used_reg != '0) && ((rd_first_reg + rd_count_reg) == start_reg);
    assign full   = used_reg >= CW'(MAX_EXTENTS);

    assign sum_oc     = off_reg + rd_count_reg;
    assign keep_whole = sum_oc <= keep_reg;
    assign head       = (keep_reg > off_reg) ? keep_reg - off_reg : 32'd0;
    assign retain     = keep_whole || (head != 32'd0);
    assign cnt_final  = (!keep_whole && head != 32'd0) ? head : rd_count_reg;
    assign acc_n      = acc_reg + cnt_final;

    always_comb begin
        we = 1'b0;
        wa = idx_reg[AW-1:0];
        wf = rd_first_reg;
        wc = head;
        if (cmd.append && len_reg != 32'd0) begin
            if (merged) begin
                we = 1'b1;
                wa = last_addr;
                wc = rd_count_reg + len_reg;
            end else if (!full) begin
                we = 1'b1;
                wa = AW'(used_reg);
                wf = start_reg;
                wc = len_reg;
            end
        end else if (cmd.step_shrink && !retain) begin
            we = 1'b0;
        end else if (cmd.step_shrink && !keep_whole) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            ext_first[wa] <= wf;
            ext_count[wa] <= wc;
        end
        if (cmd.rd_last || cmd.rd_idx) begin
            rd_first_reg <= ext_first[ra];
            rd_count_reg <= ext_count[ra];
        end
        if (cmd.step_shrink && !keep_whole) begin
            free_st[nf_reg[AW-1:0]] <= rd_first_reg + head;
            free_ln[nf_reg[AW-1:0]] <= rd_count_reg - head;
        end
        if (cmd.rd_free) begin
            rd_fs_reg <= free_st[fidx_reg[AW-1:0]];
            rd_fl_reg <= free_ln[fidx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            blocks_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                start_reg  <= s_tdata[31:0];
                len_reg    <= s_tdata[63:32];
                lblk_reg   <= s_tdata[95:64];
                keep_reg   <= s_tdata[127:96];
                idx_reg    <= '0;
                off_reg    <= '0;
                acc_reg    <= '0;
                nb_reg     <= '0;
                newn_reg   <= '0;
                nf_reg     <= '0;
                phys_reg   <= '0;
                status_reg <= 1'b0;
            end
            if (cmd.append && len_reg != 32'd0) begin
                if (merged) begin
                    blocks_reg <= blocks_reg + len_reg;
                end else if (full) begin
                    status_reg <= 1'b1;
                end else begin
                    used_reg   <= used_reg + 1'b1;
                    blocks_reg <= blocks_reg + len_reg;
                end
            end
            if (cmd.step_lookup) begin
                if (lblk_reg < sum_oc) begin
                    phys_reg <= {1'b0, rd_first_reg} + {1'b0, lblk_reg - off_reg};
                end
                off_reg <= sum_oc;
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.step_shrink) begin
                off_reg <= sum_oc;
                acc_reg <= acc_n;
                idx_reg <= idx_reg + 1'b1;
                if (!keep_whole) begin
                    nf_reg <= nf_reg + 1'b1;
                end
                if (retain) begin
                    newn_reg <= idx_reg + 1'b1;
                    nb_reg   <= acc_n;
                end
            end
            if (cmd.finish) begin
                used_reg   <= newn_reg;
                blocks_reg <= nb_reg;
                fidx_reg   <= '0;
            end
            if (cmd.load_single) begin
                m_valid_reg  <= 1'b1;
                m_status_reg <= status_reg;
                m_phys_reg   <= phys_reg;
                m_fv_reg     <= 1'b0;
                m_fs_reg     <= '0;
                m_fl_reg     <= '0;
                m_total_reg  <= 6'(used_reg);
                m_blocks_reg <= blocks_reg;
                m_last_reg   <= 1'b1;
            end else if (cmd.load_free) begin
                m_valid_reg  <= 1'b1;
                m_status_reg <= 1'b0;
                m_phys_reg   <= '0;
                m_fv_reg     <= 1'b1;
                m_fs_reg     <= rd_fs_reg;
                m_fl_reg     <= rd_fl_reg;
                m_total_reg  <= 6'(used_reg);
                m_blocks_reg <= blocks_reg;
                m_last_reg   <= sts.free_last;
                fidx_reg     <= fidx_reg + 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.walk_done = idx_reg >= used_reg;
    assign sts.hit       = lblk_reg < sum_oc;
    assign sts.nf_zero   = nf_reg == '0;
    assign sts.free_last = (fidx_reg + 1'b1) == nf_reg;
    assign sts.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {m_fv_reg, m_status_reg};
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_blocks_reg, m_total_reg, m_fl_reg, m_fs_reg, m_phys_reg};

endmodule

// ===== src/extent_map_engine.sv =====
// Append: reads the last extent, then merges into it or adds an entry.
// Lookup: reads then evaluates each extent in turn, up to the first hit or the last extent.
// Shrink: walks every extent, commits the new table, then sends each freed range in turn
// from a result buffer, or a single result when nothing is freed.
// One request at a time; the next is taken once the last result is registered.
// aresetn (synchronous, active low) empties the table; entries are not cleared.
module extent_map_engine
    import emp_pkg::*;
#(
    parameter int MAX_EXTENTS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // ext_start, ext_length, lookup_block, keep_blocks
    input  logic [1:0]   s_tuser,  // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    // phys_block, free_start, free_length, extent_total, total_blocks, pad
    output logic [135:0] m_tdata,
    output logic [1:0]   m_tuser,  // status, free_valid
    output logic         m_tlast
);

    cmd_t cmd;
    sts_t sts;

    emp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    emp_dp #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_status_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && !m_tuser[1]))
        else $error("table full flagged on a freed-range result");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> m_tlast)
        else $error("non-range result without tlast");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[102:97] <= 6'(MAX_EXTENTS)))
        else $error("extent count above table size");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the extent map engine: directed table, table fill, back-pressure and random requests.
module testbench
    import emp_pkg::*;
;

    typedef struct packed {
        logic        status;
        logic [32:0] phys;
        logic        fvalid;
        logic [31:0] fstart;
        logic [31:0] flen;
        logic [5:0]  ecount;
        logic [31:0] tblocks;
        logic        lastf;
    } map_res_t;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] a;
        logic [31:0] b;
        logic        chk;
        map_res_t    res;
    } dir_row_t;

    localparam int NEXT = 32;
    localparam int WDOG_LIMIT = 20000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    logic [31:0] ext_start_q[NEXT];
    logic [31:0] ext_len_q[NEXT];
    int unsigned ext_used;
    logic [31:0] blocks_sum;

    map_res_t expected_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_recv = 0;
    int n_free = 0;
    int n_full = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;

    extent_map_engine dut (.*);

    always #6 aclk = ~aclk;

    function automatic map_res_t mk_res(logic st, logic [32:0] ph, logic fv,
                                        logic [31:0] fs, logic [31:0] fl, logic lf);
        map_res_t r;
        r.status = st; r.phys = ph; r.fvalid = fv; r.fstart = fs; r.flen = fl;
        r.ecount = ext_used[5:0]; r.tblocks = blocks_sum; r.lastf = lf;
        return r;
    endfunction

    function automatic void resum();
        logic [31:0] s;
        s = '0;
        for (int i = 0; i < ext_used; i++) s += ext_len_q[i];
        blocks_sum = s;
    endfunction

    // queues the expected results of one request in order and updates the table model
    function automatic void map_predict(logic [1:0] req, logic [31:0] ea, logic [31:0] eb,
                                        logic [31:0] lb, logic [31:0] kb);
        logic [31:0] off, c, head;
        logic [32:0] ph;
        logic st;
        bit merged;
        int unsigned new_n;
        logic [31:0] fs[$];
        logic [31:0] fl[$];
        st = 1'b0; ph = '0; off = '0; merged = 1'b0; new_n = 0;
        case (req)
            REQ_APPEND: begin
                if (eb != 0) begin
                    if (ext_used > 0 &&
                        ext_start_q[ext_used-1] + ext_len_q[ext_used-1] == ea) begin
                        ext_len_q[ext_used-1] += eb;
                        merged = 1'b1;
                    end
                    if (!merged) begin
                        if (ext_used >= NEXT) begin
                            st = 1'b1;
                            n_full++;
                        end else begin
                            ext_start_q[ext_used] = ea;
                            ext_len_q[ext_used] = eb;
                            ext_used++;
                        end
                    end
                    resum();
                end
                expected_q.push_back(mk_res(st, '0, 1'b0, '0, '0, 1'b1));
            end
            REQ_LOOKUP: begin
                for (int i = 0; i < ext_used; i++) begin
                    c = ext_len_q[i];
                    if (lb < off + c) begin
                        ph = {1'b0, ext_start_q[i]} + {1'b0, lb - off};
                        break;
                    end
                    off += c;
                end
                expected_q.push_back(mk_res(1'b0, ph, 1'b0, '0, '0, 1'b1));
            end
            REQ_SHRINK: begin
                for (int i = 0; i < ext_used; i++) begin
                    c = ext_len_q[i];
                    if (off + c <= kb) begin
                        off += c;
                        new_n = i + 1;
                        continue;
                    end
                    head = (kb > off) ? kb - off : '0;
                    fs.push_back(ext_start_q[i] + head);
                    fl.push_back(c - head);
                    off += c;
                    if (head != 0) begin
                        ext_len_q[i] = head;
                        new_n = i + 1;
                    end
                end
                ext_used = new_n;
                resum();
                if (fs.size() == 0) begin
                    expected_q.push_back(mk_res(1'b0, '0, 1'b0, '0, '0, 1'b1));
                end
                for (int k = 0; k < fs.size(); k++) begin
                    expected_q.push_back(mk_res(1'b0, '0, 1'b1, fs[k], fl[k],
                                                k == fs.size() - 1));
                    n_free++;
                end
            end
            default: expected_q.push_back(mk_res(1'b0, '0, 1'b0, '0, '0, 1'b1));
        endcase
    endfunction

    task automatic send_req(logic [1:0] req, logic [31:0] a, logic [31:0] b,
                            logic [31:0] lb, logic [31:0] kb);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {kb, lb, b, a};
        do @(posedge aclk); while (!s_tready);
        map_predict(req, a, b, lb, kb);
        n_sent++;
    endtask

    task automatic gap(int n);
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata <= {$urandom, $urandom, $urandom, $urandom};
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic rand_req(int mode);
        logic [1:0] rq;
        logic [31:0] a, b, v;
        int pick;
        pick = $urandom_range(0, 99);
        rq = pick < 55 ? REQ_APPEND : pick < 85 ? REQ_LOOKUP :
             pick < 97 ? REQ_SHRINK : REQ_UNUSED;
        b = (mode == 0) ? $urandom_range(0, 40) : $urandom;
        if ($urandom_range(0, 2) != 0 && ext_used > 0)
            a = ext_start_q[ext_used-1] + ext_len_q[ext_used-1];
        else
            a = $urandom;
        v = (mode == 0 || $urandom_range(0, 3) != 0) ?
            $urandom_range(0, blocks_sum + 8) : $urandom;
        if (rq == REQ_SHRINK && $urandom_range(0, 2) == 0 && ext_used > 24) v = 0;
        send_req(rq, a, b, v, v);
    endtask

    // receiver: own stall pattern, plus long hold-off when requested
    always @(negedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 9) < 7) || (idle_cycles % 40 < 10);
    end

    always @(posedge aclk) begin
        map_res_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser[0];
            got.fvalid = m_tuser[1];
            got.phys = m_tdata[32:0];
            got.fstart = m_tdata[64:33];
            got.flen = m_tdata[96:65];
            got.ecount = m_tdata[102:97];
            got.tblocks = m_tdata[134:103];
            got.lastf = m_tlast;
            n_recv++;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    $display("%0t mismatch expected %h actual %h", $time, exp_r, got);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t watchdog expired", $time);
            $display("testbench failed");
            $finish;
        end
    end

    dir_row_t dir_tab[$];

    function automatic dir_row_t row(logic [1:0] rq, logic [31:0] a, logic [31:0] b,
                                     logic c, map_res_t r);
        dir_row_t d;
        d.req = rq; d.a = a; d.b = b; d.chk = c; d.res = r;
        return d;
    endfunction

    initial begin
        map_res_t z;
        z = '0;
        ext_used = 0;
        blocks_sum = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // a = start/lookup/keep, b = length
        z.lastf = 1'b1;
        dir_tab.push_back(row(REQ_LOOKUP, 32'd0, 32'd0, 1'b1, z));
        dir_tab.push_back(row(REQ_SHRINK, 32'd0, 32'd0, 1'b1, z));
        dir_tab.push_back(row(REQ_APPEND, 32'd5, 32'd0, 1'b1, z));
        dir_tab.push_back(row(REQ_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, z));
        dir_tab.push_back(row(REQ_APPEND, 32'd100, 32'd10, 1'b0, z));
        dir_tab.push_back(row(REQ_APPEND, 32'd110, 32'd5, 1'b0, z));
        dir_tab.push_back(row(REQ_APPEND, 32'hFFFFFFF0, 32'hFFFFFFFF, 1'b0, z));
        dir_tab.push_back(row(REQ_APPEND, 32'hFFFFFFEF, 32'd3, 1'b0, z));
        dir_tab.push_back(row(REQ_APPEND, 32'd0, 32'd20, 1'b0, z));
        dir_tab.push_back(row(REQ_LOOKUP, 32'd0, 32'd0, 1'b0, z));
        dir_tab.push_back(row(REQ_LOOKUP, 32'd14, 32'd0, 1'b0, z));
        dir_tab.push_back(row(REQ_LOOKUP, 32'd15, 32'd0, 1'b0, z));
        dir_tab.push_back(row(REQ_LOOKUP, 32'hFFFFFFFF, 32'd0, 1'b0, z));
        dir_tab.push_back(row(REQ_SHRINK, 32'd12, 32'd0, 1'b0, z));
        dir_tab.push_back(row(REQ_SHRINK, 32'hFFFFFFFF, 32'd0, 1'b0, z));
        dir_tab.push_back(row(REQ_SHRINK, 32'd0, 32'd0, 1'b0, z));
        for (int i = 0; i < dir_tab.size(); i++) begin
            send_req(dir_tab[i].req, dir_tab[i].a, dir_tab[i].b, dir_tab[i].a,
                     dir_tab[i].a);
            if (dir_tab[i].chk) expected_q[$] = dir_tab[i].res;
        end
        // fill the table: 33 non-contiguous appends, the last hits full
        for (int i = 0; i < 33; i++) begin
            send_req(REQ_APPEND, 32'd1000 * i, 32'd7, '0, '0);
            if (i == 32) expected_q[$] = mk_res(1'b1, '0, 1'b0, '0, '0, 1'b1);
        end
        send_req(REQ_APPEND, 32'd31007, 32'd2, '0, '0);
        // back-pressure: receiver held off while sender keeps offering
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                send_req(REQ_SHRINK, 32'd0, 32'd0, 32'd0, 32'd3);
                send_req(REQ_LOOKUP, 32'd0, 32'd0, 32'd1, 32'd0);
                send_req(REQ_APPEND, 32'd9, 32'd4, 32'd0, 32'd0);
            end
        join
        for (int n = 0; n < 170; ) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) begin
                rand_req(n < 120 ? 0 : 1);
                n++;
            end
            gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25));
        end
        @(negedge aclk) s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (100) @(posedge aclk);
        $display("Sent %0d requests, got %0d results (%0d freed ranges, %0d table-full).",
                 n_sent, n_recv, n_free, n_full);
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
